FILE: hw/rtl/rmts_pkg.sv
// Package for the rate-monotonic tick scheduler.
// Holds the shared types, port widths and default sizes.
// Used by the controller, datapath and top level; depends on nothing.
`timescale 1ns / 1ps

package rmts_pkg;

   localparam int MAX_TASKS_DEF = 8;
   localparam int TIME_BITS_DEF = 16;

   localparam int INDEX_W = 3;
   localparam int FIELD_W = 16;
   localparam int ACTIVE_W = 4;
   localparam int TOTAL_W = 16;
   localparam int KIND_W = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_IDLE   = 2'd0,
      KIND_NORMAL = 2'd1,
      KIND_LATE   = 2'd2,
      KIND_LOAD   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_UPDATE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic update;
      logic scan_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/rmts_ctrl.sv
// Controller state machine of the rate-monotonic tick scheduler.
// Sequences load, release update, winner scan and commit; uses rmts_pkg.
`timescale 1ns / 1ps

module rmts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,
   output logic                   req_tready,
   input  rmts_pkg::dp_status_type status,
   output rmts_pkg::ctrl_cmd_type  cmd
);
   import rmts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = req_tuser ? ST_UPDATE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/rmts_datapath.sv
// Datapath of the rate-monotonic tick scheduler: task lanes, winner scan,
// preemption bookkeeping and the result register. Uses rmts_pkg.
`timescale 1ns / 1ps

module rmts_datapath #(
   parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rmts_pkg::ctrl_cmd_type            cmd,
   output rmts_pkg::dp_status_type           status,
   input  logic [rmts_pkg::INDEX_W-1:0]      in_index,
   input  logic [rmts_pkg::FIELD_W-1:0]      in_compute,
   input  logic [rmts_pkg::FIELD_W-1:0]      in_period,
   input  logic                              in_final,
   input  logic                              csr_wen,
   input  logic [rmts_pkg::ACTIVE_W-1:0]     csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rmts_pkg::KIND_W-1:0]       rsp_kind,
   output logic [rmts_pkg::INDEX_W-1:0]      rsp_task,
   output logic                              rsp_preempted,
   output logic                              rsp_missed,
   output logic [rmts_pkg::TOTAL_W-1:0]      rsp_total
);
   import rmts_pkg::*;

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic [TIME_BITS-1:0] budget_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] budget_in [MAX_TASKS];
   logic [TIME_BITS-1:0] period_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] period_in [MAX_TASKS];
   logic [TIME_BITS-1:0] remain_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] remain_in [MAX_TASKS];
   logic [TIME_BITS-1:0] debt_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] debt_in [MAX_TASKS];
   logic [TIME_BITS-1:0] phase_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] phase_in [MAX_TASKS];

   logic [ACTIVE_W-1:0]  active_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic [TIME_BITS-1:0] ct_ff;
   logic [TIME_BITS-1:0] pd_ff;
   logic                 fin_ff;

   logic                 first_ff;
   logic                 first_in;
   kind_type             prev_kind_ff;
   kind_type             prev_kind_in;
   logic [IDX_W-1:0]     prev_task_ff;
   logic [IDX_W-1:0]     prev_task_in;
   logic [TOTAL_W-1:0]   count_ff;
   logic [TOTAL_W-1:0]   count_in;
   logic                 missed_ff;
   logic                 missed_in;

   logic [IDX_W-1:0]     scan_ff;
   logic [IDX_W-1:0]     scan_in;
   logic                 found_ff;
   logic                 found_in;
   logic [IDX_W-1:0]     best_ff;
   logic [IDX_W-1:0]     best_in;
   logic [TIME_BITS-1:0] best_period_ff;
   logic [TIME_BITS-1:0] best_period_in;
   logic [TIME_BITS-1:0] best_budget_ff;
   logic [TIME_BITS-1:0] best_budget_in;
   logic                 best_late_ff;
   logic                 best_late_in;
   logic                 prev_ready_ff;
   logic                 prev_ready_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   kind_type             rsp_kind_ff;
   kind_type             rsp_kind_in;
   logic [INDEX_W-1:0]   rsp_task_ff;
   logic [INDEX_W-1:0]   rsp_task_in;
   logic                 rsp_pre_ff;
   logic                 rsp_pre_in;
   logic                 rsp_missed_ff;
   logic                 rsp_missed_in;
   logic [TOTAL_W-1:0]   rsp_total_ff;
   logic [TOTAL_W-1:0]   rsp_total_in;

   logic [CNT_W-1:0]     n_eff;
   logic                 load_hit;
   logic [TIME_BITS-1:0] pd_fix;
   logic                 scan_ready;
   logic                 scan_better;
   kind_type             win_kind;
   logic [IDX_W-1:0]     win_task;
   logic                 win_pre;
   logic                 win_same;
   logic                 out_free;

   assign n_eff = (32'(active_ff) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(active_ff);
   assign load_hit = 32'(idx_ff) < MAX_TASKS;
   assign pd_fix = (pd_ff == '0) ? TIME_BITS'(1) : pd_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign status.out_free = out_free;
   assign status.scan_last = 32'(scan_ff) == (MAX_TASKS - 1);

   always_comb begin
      logic rel;
      logic [TIME_BITS:0] phase_next;
      for (int i = 0; i < MAX_TASKS; i++) begin
         budget_in[i] = budget_ff[i];
         period_in[i] = period_ff[i];
         remain_in[i] = remain_ff[i];
         debt_in[i] = debt_ff[i];
         phase_in[i] = phase_ff[i];
      end
      missed_in = missed_ff;
      rel = 1'b0;
      phase_next = '0;
      if (cmd.load) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            if (load_hit && (32'(idx_ff) == i)) begin
               budget_in[i] = ct_ff;
               period_in[i] = pd_fix;
               remain_in[i] = ct_ff;
            end else begin
               remain_in[i] = budget_ff[i];
            end
            debt_in[i] = '0;
            phase_in[i] = '0;
         end
      end else if (cmd.update) begin
         missed_in = 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            rel = (CNT_W'(i) < n_eff) && !first_ff && (phase_ff[i] == '0);
            if (rel) begin
               if (remain_ff[i] != '0) begin
                  missed_in = 1'b1;
                  if (debt_ff[i] != TIME_MAX) begin
                     debt_in[i] = debt_ff[i] + TIME_BITS'(1);
                  end
               end
               remain_in[i] = budget_ff[i];
            end
            phase_next = {1'b0, phase_ff[i]} + (TIME_BITS + 1)'(1);
            phase_in[i] = (phase_next >= {1'b0, period_ff[i]}) ? '0
                                                             : phase_next[TIME_BITS-1:0];
         end
      end else if (cmd.commit && found_ff) begin
         if (best_late_ff) begin
            debt_in[best_ff] = debt_ff[best_ff] - TIME_BITS'(1);
         end else begin
            remain_in[best_ff] = remain_ff[best_ff] - TIME_BITS'(1);
         end
      end
   end

   assign scan_ready = (CNT_W'(scan_ff) < n_eff) && (remain_ff[scan_ff] != '0);
   assign scan_better = !found_ff || (period_ff[scan_ff] < best_period_ff) ||
                        ((period_ff[scan_ff] == best_period_ff) &&
                         (budget_ff[scan_ff] < best_budget_ff));

   always_comb begin
      scan_in = scan_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_period_in = best_period_ff;
      best_budget_in = best_budget_ff;
      best_late_in = best_late_ff;
      prev_ready_in = prev_ready_ff;
      if (cmd.update) begin
         scan_in = '0;
         found_in = 1'b0;
         prev_ready_in = 1'b0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + IDX_W'(1);
         if (scan_ff == prev_task_ff) begin
            prev_ready_in = scan_ready;
         end
         if (scan_ready && scan_better) begin
            found_in = 1'b1;
            best_in = scan_ff;
            best_period_in = period_ff[scan_ff];
            best_budget_in = budget_ff[scan_ff];
            best_late_in = debt_ff[scan_ff] != '0;
         end
      end
   end

   always_comb begin
      if (!found_ff) begin
         win_kind = KIND_IDLE;
         win_task = '0;
      end else if (best_late_ff) begin
         win_kind = KIND_LATE;
         win_task = best_ff;
      end else begin
         win_kind = KIND_NORMAL;
         win_task = best_ff;
      end
      win_same = (win_kind == prev_kind_ff) && (win_task == prev_task_ff);
      if (!found_ff) begin
         win_pre = fin_ff;
      end else begin
         win_pre = !first_ff && !win_same &&
                   (((prev_kind_ff == KIND_NORMAL) && prev_ready_ff) ||
                    (prev_kind_ff == KIND_IDLE));
      end
   end

   always_comb begin
      first_in = first_ff;
      prev_kind_in = prev_kind_ff;
      prev_task_in = prev_task_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_task_in = rsp_task_ff;
      rsp_pre_in = rsp_pre_ff;
      rsp_missed_in = rsp_missed_ff;
      rsp_total_in = rsp_total_ff;
      if (cmd.load) begin
         first_in = 1'b1;
         prev_kind_in = KIND_IDLE;
         prev_task_in = '0;
         count_in = '0;
         rsp_valid_in = 1'b1;
         rsp_kind_in = KIND_LOAD;
         rsp_task_in = idx_ff;
         rsp_pre_in = 1'b0;
         rsp_missed_in = 1'b0;
         rsp_total_in = '0;
      end else if (cmd.commit) begin
         if (win_pre && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + TOTAL_W'(1);
         end
         first_in = 1'b0;
         prev_kind_in = win_kind;
         prev_task_in = win_task;
         rsp_valid_in = 1'b1;
         rsp_kind_in = win_kind;
         rsp_task_in = INDEX_W'(win_task);
         rsp_pre_in = win_pre;
         rsp_missed_in = missed_ff;
         rsp_total_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            budget_ff[i] <= '0;
            period_ff[i] <= TIME_BITS'(1);
            remain_ff[i] <= '0;
            debt_ff[i] <= '0;
            phase_ff[i] <= '0;
         end
         active_ff <= ACTIVE_RESET;
         first_ff <= 1'b1;
         prev_kind_ff <= KIND_IDLE;
         prev_task_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            budget_ff[i] <= budget_in[i];
            period_ff[i] <= period_in[i];
            remain_ff[i] <= remain_in[i];
            debt_ff[i] <= debt_in[i];
            phase_ff[i] <= phase_in[i];
         end
         if (csr_wen) begin
            active_ff <= csr_wdata;
         end
         first_ff <= first_in;
         prev_kind_ff <= prev_kind_in;
         prev_task_ff <= prev_task_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= in_index;
         ct_ff <= TIME_BITS'(in_compute);
         pd_ff <= TIME_BITS'(in_period);
         fin_ff <= in_final;
      end
      missed_ff <= missed_in;
      scan_ff <= scan_in;
      found_ff <= found_in;
      best_ff <= best_in;
      best_period_ff <= best_period_in;
      best_budget_ff <= best_budget_in;
      best_late_ff <= best_late_in;
      prev_ready_ff <= prev_ready_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_task_ff <= rsp_task_in;
      rsp_pre_ff <= rsp_pre_in;
      rsp_missed_ff <= rsp_missed_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_task = rsp_task_ff;
   assign rsp_preempted = rsp_pre_ff;
   assign rsp_missed = rsp_missed_ff;
   assign rsp_total = rsp_total_ff;

endmodule

FILE: hw/rtl/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler. A load item (tuser 0) writes one task slot's
// compute time and period and restarts the run. A tick item (tuser 1) reloads
// budgets at period boundaries, then scans the task slots one per cycle for the
// shortest-period ready task. Each result is registered in the LOAD or COMMIT
// state once the output is free. The block takes one item at a time and
// accepts the next one in the cycle after the previous result is registered.
// A result waiting on the output does not stop that, but the next result is
// held back until the output register has drained.
// Depends on rmts_pkg, rmts_ctrl and rmts_datapath.
`timescale 1ns / 1ps

module rate_monotonic_tick_scheduler #(
   parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: task_index [2:0], compute_time [18:3], period [34:19], zeros above.
   input  logic [rmts_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: cmd.
   input  logic                                 req_tuser,
   // req_tlast: final_tick.
   input  logic                                 req_tlast,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: chosen_task [2:0], preempted [3], deadline_missed [4],
   // preemption_total [20:5], zeros above.
   output logic [rmts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: slot_kind.
   output logic [rmts_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_wen,
   input  logic [rmts_pkg::ACTIVE_W-1:0]        csr_wdata
);
   import rmts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [INDEX_W-1:0] rsp_task;
   logic               rsp_preempted;
   logic               rsp_missed;
   logic [TOTAL_W-1:0] rsp_total;

   rmts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rmts_datapath #(
      .MAX_TASKS (MAX_TASKS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_index      (req_tdata[2:0]),
      .in_compute    (req_tdata[18:3]),
      .in_period     (req_tdata[34:19]),
      .in_final      (req_tlast),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_kind      (rsp_tuser),
      .rsp_task      (rsp_task),
      .rsp_preempted (rsp_preempted),
      .rsp_missed    (rsp_missed),
      .rsp_total     (rsp_total)
   );

   assign rsp_tdata = {3'b000, rsp_total, rsp_missed, rsp_preempted, rsp_task};

endmodule
